@@ design/see_pkg.sv @@
`timescale 1ns / 1ps
package see_pkg;
  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int TOKEN_W = 8;
  localparam int ERR_W = 3;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_FULL      = 3'd4;

  localparam logic [TOKEN_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [TOKEN_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [TOKEN_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [TOKEN_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [TOKEN_W-1:0] CH_PCT   = 8'h25;
  localparam logic [TOKEN_W-1:0] CH_SPACE = 8'h20;
  localparam logic [TOKEN_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [TOKEN_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_REM = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;
endpackage

@@ design/see_if.sv @@
`timescale 1ns / 1ps
interface see_in_if import see_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] token;
  logic               prefix_order;
  logic               last;
  modport source (output valid, token, prefix_order, last, input ready);
  modport sink   (input valid, token, prefix_order, last, output ready);
endinterface

interface see_out_if import see_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [ERR_W-1:0]         error_code;
  modport source (output valid, value, error_code, input ready);
  modport sink   (input valid, value, error_code, output ready);
endinterface

@@ design/see_serial_alu.sv @@
`timescale 1ns / 1ps
// bit-serial multiply (shift-add) and restoring divide, one bit per cycle
module see_serial_alu import see_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  alu_cmd_t          cmd,
  input  logic [DATA_W-1:0] lhs,
  input  logic [DATA_W-1:0] rhs,
  output logic              done,
  output logic [DATA_W-1:0] result
);
  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  alu_op_t           op_r, op_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;   // product or remainder
  logic [DATA_W-1:0] sh_r, sh_nxt;     // multiplier or quotient
  logic [DATA_W-1:0] d_r, d_nxt;       // multiplicand or divisor magnitude
  logic              nneg_r, nneg_nxt, qneg_r, qneg_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] lmag, rmag;

  assign lmag  = lhs[DATA_W-1] ? (~lhs + 1'b1) : lhs;
  assign rmag  = rhs[DATA_W-1] ? (~rhs + 1'b1) : rhs;
  assign trial = {acc_r, sh_r[DATA_W-1]} - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r; cnt_nxt = cnt_r; op_nxt = op_r;
    acc_nxt = acc_r; sh_nxt = sh_r; d_nxt = d_r;
    nneg_nxt = nneg_r; qneg_nxt = qneg_r; done_nxt = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      op_nxt   = cmd.op;
      acc_nxt  = '0;
      nneg_nxt = lhs[DATA_W-1];
      qneg_nxt = lhs[DATA_W-1] ^ rhs[DATA_W-1];
      if (cmd.op == OP_MUL) begin
        sh_nxt = rhs; d_nxt = lhs;
      end else begin
        sh_nxt = lmag; d_nxt = rmag;
      end
    end else if (busy_r) begin
      if (op_r == OP_MUL) begin
        acc_nxt = (acc_r << 1) + (sh_r[DATA_W-1] ? d_r : '0);
        sh_nxt  = sh_r << 1;
      end else if (!trial[DATA_W]) begin
        acc_nxt = trial[DATA_W-1:0];
        sh_nxt  = {sh_r[DATA_W-2:0], 1'b1};
      end else begin
        acc_nxt = {acc_r[DATA_W-2:0], sh_r[DATA_W-1]};
        sh_nxt  = {sh_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0; op_r <= OP_MUL;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt; op_r <= op_nxt;
    end
    acc_r <= acc_nxt; sh_r <= sh_nxt; d_r <= d_nxt;
    nneg_r <= nneg_nxt; qneg_r <= qneg_nxt;
  end

  always_comb begin
    case (op_r)
      OP_MUL:  result = acc_r;
      OP_DIV:  result = qneg_r ? (~sh_r + 1'b1) : sh_r;
      OP_REM:  result = nneg_r ? (~acc_r + 1'b1) : acc_r;
      default: result = acc_r;
    endcase
  end
  assign done = done_r;
endmodule

@@ design/stack_expression_evaluator_top.sv @@
`timescale 1ns / 1ps
// Postfix/prefix expression evaluator. One ASCII character per word; digits
// push, + - * / % pop two and push. A digit, a space, a bad character, an
// underflow or any character after an error passes through the accept,
// decode and finish states. + or - and a divide by zero add an operate
// state. * / % with a nonzero divisor add the operate state and then wait on
// the one-bit-per-cycle serial multiply/divide unit until it is done.
// A result word appears only on the last character; it holds the top of
// stack (0 on error) and the first error code. The output register lets the
// next expression start while a result waits; only a last character stalls in
// its finish state until the previous result has been taken. A new character
// is accepted only in the idle state, after the previous one has finished.
module stack_expression_evaluator_top import see_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input logic clk,
  input logic rst_n,
  see_in_if.sink    in_ch,
  see_out_if.source out_ch
);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int IX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_OPER, S_WAIT, S_FIN
  } state_t;

  state_t            state_r;
  logic [SP_W-1:0]   sp_r;
  logic [ERR_W-1:0]  err_r;
  logic [TOKEN_W-1:0] tok_r;
  logic              pre_r, last_r;
  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] top_r, sec_r;      // registered memory reads
  logic [DATA_W-1:0] res_r;
  logic              ov_r;
  logic [DATA_W-1:0] ovalue_r;
  logic [ERR_W-1:0]  oerr_r;
  alu_cmd_t          cmd;
  logic              alu_done;
  logic [DATA_W-1:0] alu_res, lhs, rhs;
  logic              accept;
  logic              out_load;
  logic              is_digit, is_op, is_div;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign is_digit = (tok_r >= CH_ZERO) && (tok_r <= CH_NINE);
  assign is_op    = (tok_r == CH_PLUS) || (tok_r == CH_MINUS) || (tok_r == CH_STAR) ||
                    (tok_r == CH_SLASH) || (tok_r == CH_PCT);
  assign is_div   = (tok_r == CH_SLASH) || (tok_r == CH_PCT);
  // prefix order swaps which pop is the left operand
  assign lhs = pre_r ? top_r : sec_r;
  assign rhs = pre_r ? sec_r : top_r;
  // last character loads the output register once it is free or being taken
  assign out_load = (state_r == S_FIN) && last_r && (!ov_r || out_ch.ready);

  always_comb begin
    cmd.start = (state_r == S_OPER) && ((tok_r == CH_STAR) ||
                ((tok_r == CH_SLASH || tok_r == CH_PCT) && rhs != '0));
    case (tok_r)
      CH_STAR:  cmd.op = OP_MUL;
      CH_SLASH: cmd.op = OP_DIV;
      default:  cmd.op = OP_REM;
    endcase
  end

  see_serial_alu u_alu (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .lhs(lhs), .rhs(rhs),
    .done(alu_done), .result(alu_res)
  );

  // operand stack memory, two registered read ports
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      top_r <= mem[IX_W'(sp_r - 1'b1)];
      sec_r <= mem[IX_W'(sp_r - 2'd2)];
    end
    if (state_r == S_READ && err_r == ERR_OK && is_digit && sp_r < SP_W'(STACK_DEPTH))
      mem[IX_W'(sp_r)] <= DATA_W'(tok_r - CH_ZERO);
    else if (state_r == S_FIN && err_r == ERR_OK && is_op)
      mem[IX_W'(sp_r - 2'd2)] <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sp_r <= '0; err_r <= ERR_OK; ov_r <= 1'b0;
    end else begin
      if (out_load) ov_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) state_r <= S_READ;
        S_READ: begin
          if (err_r != ERR_OK || tok_r == CH_SPACE) state_r <= S_FIN;
          else if (is_digit) begin
            if (sp_r >= SP_W'(STACK_DEPTH)) err_r <= ERR_FULL;
            else sp_r <= sp_r + 1'b1;
            state_r <= S_FIN;
          end else if (is_op) begin
            if (sp_r < SP_W'(2)) begin
              err_r <= ERR_UNDERFLOW; state_r <= S_FIN;
            end else state_r <= S_OPER;
          end else begin
            err_r <= ERR_BAD_CHAR; state_r <= S_FIN;
          end
        end
        S_OPER: begin
          if (is_div && rhs == '0) begin
            err_r <= ERR_DIV_ZERO; state_r <= S_FIN;
          end else if (tok_r == CH_PLUS) begin
            res_r <= lhs + rhs; state_r <= S_FIN;
          end else if (tok_r == CH_MINUS) begin
            res_r <= lhs - rhs; state_r <= S_FIN;
          end else state_r <= S_WAIT;
        end
        S_WAIT: if (alu_done) begin
          res_r <= alu_res; state_r <= S_FIN;
        end
        S_FIN: begin
          // waits here only if a previous result is still untaken
          if (!last_r) begin
            if (err_r == ERR_OK && is_op) sp_r <= sp_r - 1'b1;
            state_r <= S_IDLE;
          end else if (out_load) begin
            if (err_r != ERR_OK) begin
              oerr_r <= err_r; ovalue_r <= '0;
            end else if (is_op) begin
              oerr_r <= ERR_OK; ovalue_r <= res_r;
            end else if (sp_r == '0) begin
              oerr_r <= ERR_UNDERFLOW; ovalue_r <= '0;
            end else begin
              oerr_r <= ERR_OK;
              ovalue_r <= is_digit ? DATA_W'(tok_r - CH_ZERO) : top_r;
            end
            sp_r <= '0; err_r <= ERR_OK; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (accept) begin
      tok_r <= in_ch.token; pre_r <= in_ch.prefix_order; last_r <= in_ch.last;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.value      = ovalue_r;
  assign out_ch.error_code = oerr_r;
endmodule

@@ design/see_checker.sv @@
`timescale 1ns / 1ps
module see_checker import see_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_value,
  input logic [ERR_W-1:0]  out_error_code
);
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code <= ERR_FULL) else $error("bad error code");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_OK) |-> out_value == '0)
    else $error("nonzero value with error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_value))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready while busy");
endmodule

bind stack_expression_evaluator_top see_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_value(out_ch.value),
  .out_error_code(out_ch.error_code)
);
